// ===== design/kis_pkg.sv =====
// Shared types and constants for the kinematic integrator with speed clamp.
package kis_pkg;

    // Register addresses on the configuration port (byte addresses).
    localparam logic [3:0] ADDR_MAX_SPEED = 4'h0;
    localparam logic [3:0] ADDR_START_X   = 4'h4;
    localparam logic [3:0] ADDR_START_Y   = 4'h8;

    localparam logic [30:0] MAX_SPEED_RESET = 31'd6553600;

    // Number of steps of the bit-serial square root and divider.
    localparam int unsigned ITER_STEPS = 32;

    // Input kind codes.
    localparam logic KIND_STEP    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Axis indexes of the three integrated quantities.
    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_ANG = 2'd2;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DT2,
        OP_DRIFT,
        OP_DV,
        OP_ACC,
        OP_UPDATE,
        OP_SQX,
        OP_SQY,
        OP_LIM,
        OP_TEST,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_MUL,
        OP_DIV_LOAD,
        OP_DIV_STEP
    } kis_op_t;

    typedef struct packed {
        kis_op_t    op;
        logic [1:0] axis;
        logic       comp;
        logic       store;
        logic       publish;
    } kis_cmd_t;

    typedef struct packed {
        logic need_clamp;
    } kis_sts_t;

    // Saturate a 36-bit signed sum to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [35:0] x);
        logic [31:0] r;
        if (x > 36'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (x < -36'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    // True when a 36-bit signed sum lies outside the signed 32-bit range.
    function automatic logic ovf32(input logic signed [35:0] x);
        return (x > 36'sh0_7FFF_FFFF) || (x < -36'sh0_8000_0000);
    endfunction

endpackage

// ===== design/kinematic_integrator_speed_clamp.sv =====
// Top level of the kinematic integrator with speed clamp.
// Each integrate item advances a 2D body one Newton-Euler step in Q16.16, and
// each item returns one result item with the new state. When the speed limit
// is exceeded, the clamp runs a 32-step square root and then two 32-step
// divides on one shared multiplier. A new item is accepted once the previous
// one has finished its work, even while its result still waits on the output.
// Configuration registers sit on the APB port: max_speed at 0x0, start_x at
// 0x4, start_y at 0x8.
module kinematic_integrator_speed_clamp (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [31:0] accel_x,
    input  logic [31:0] accel_y,
    input  logic [31:0] angular_accel,
    input  logic [15:0] time_step,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] heading,
    output logic [31:0] vel_x,
    output logic [31:0] vel_y,
    output logic [31:0] spin,
    output logic        clamped,
    output logic        saturated
);
    import kis_pkg::*;

    logic [30:0] max_speed_reg;
    logic [31:0] start_x_reg;
    logic [31:0] start_y_reg;
    logic        cfg_wr;
    kis_cmd_t    cmd;
    kis_sts_t    sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RESET;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_MAX_SPEED: max_speed_reg <= pwdata[30:0];
                ADDR_START_X:   start_x_reg   <= pwdata;
                ADDR_START_Y:   start_y_reg   <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        unique case (paddr)
            ADDR_MAX_SPEED: prdata = {1'b0, max_speed_reg};
            ADDR_START_X:   prdata = start_x_reg;
            ADDR_START_Y:   prdata = start_y_reg;
            default:        prdata = '0;
        endcase
    end

    kis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_kind   (kind),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kis_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (kind),
        .in_accel_x    (accel_x),
        .in_accel_y    (accel_y),
        .in_accel_w    (angular_accel),
        .in_dt         (time_step),
        .max_speed     (max_speed_reg),
        .start_x       (start_x_reg),
        .start_y       (start_y_reg),
        .res_pos_x     (pos_x),
        .res_pos_y     (pos_y),
        .res_heading   (heading),
        .res_vel_x     (vel_x),
        .res_vel_y     (vel_y),
        .res_spin      (spin),
        .res_clamped   (clamped),
        .res_saturated (saturated)
    );

endmodule

// ===== design/kis_ctrl.sv =====
// Controller state machine that sequences the integrator datapath.
module kis_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  kis_pkg::kis_sts_t sts,
    output kis_pkg::kis_cmd_t cmd
);
    import kis_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DT2,
        S_DRIFT,
        S_DV,
        S_ACC,
        S_UPD,
        S_SQX,
        S_SQY,
        S_LIM,
        S_TEST,
        S_CHK,
        S_SQI,
        S_SQS,
        S_DMUL,
        S_DLD,
        S_DSTEP,
        S_DST,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       comp_reg, comp_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       can_publish;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign can_publish = !out_valid_reg || out_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        comp_next      = comp_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '{op: OP_NONE, axis: axis_reg, comp: comp_reg,
                           store: 1'b0, publish: 1'b0};
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op     = OP_LOAD;
                    axis_next  = AXIS_X;
                    comp_next  = 1'b0;
                    state_next = (in_kind == KIND_RESTART) ? S_DONE : S_DT2;
                end
            end
            S_DT2:
            begin
                cmd.op     = OP_DT2;
                state_next = S_DRIFT;
            end
            S_DRIFT:
            begin
                cmd.op     = OP_DRIFT;
                state_next = S_DV;
            end
            S_DV:
            begin
                cmd.op     = OP_DV;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.op = OP_UPDATE;
                if (axis_reg == AXIS_ANG)
                begin
                    state_next = S_SQX;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DRIFT;
                end
            end
            S_SQX:
            begin
                cmd.op     = OP_SQX;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = OP_SQY;
                state_next = S_LIM;
            end
            S_LIM:
            begin
                cmd.op     = OP_LIM;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.op     = OP_TEST;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = sts.need_clamp ? S_SQI : S_DONE;
            end
            S_SQI:
            begin
                cmd.op     = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ITER_STEPS - 1))
                begin
                    state_next = S_DMUL;
                end
            end
            S_DMUL:
            begin
                cmd.op     = OP_DIV_MUL;
                state_next = S_DLD;
            end
            S_DLD:
            begin
                cmd.op     = OP_DIV_LOAD;
                cnt_next   = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(ITER_STEPS - 1))
                begin
                    state_next = S_DST;
                end
            end
            S_DST:
            begin
                cmd.store = 1'b1;
                if (comp_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    comp_next  = 1'b1;
                    state_next = S_DMUL;
                end
            end
            S_DONE:
            begin
                if (can_publish)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= AXIS_X;
            comp_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            comp_reg      <= comp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A publish always leaves a valid result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("result not presented after publish");

    // An accepted item always starts work.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start");

    // The axis counter never leaves its three axes.
    assert property (@(posedge clk) disable iff (!rst_n)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

endmodule

// ===== design/kis_dp.sv =====
// Datapath: shared multiplier, state registers, square root and divider.
module kis_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  kis_pkg::kis_cmd_t cmd,
    output kis_pkg::kis_sts_t sts,
    input  logic              in_kind,
    input  logic [31:0]       in_accel_x,
    input  logic [31:0]       in_accel_y,
    input  logic [31:0]       in_accel_w,
    input  logic [15:0]       in_dt,
    input  logic [30:0]       max_speed,
    input  logic [31:0]       start_x,
    input  logic [31:0]       start_y,
    output logic [31:0]       res_pos_x,
    output logic [31:0]       res_pos_y,
    output logic [31:0]       res_heading,
    output logic [31:0]       res_vel_x,
    output logic [31:0]       res_vel_y,
    output logic [31:0]       res_spin,
    output logic              res_clamped,
    output logic              res_saturated
);
    import kis_pkg::*;

    // Body state, indexed by axis (x, y, angle).
    logic [31:0] pos_reg [3];
    logic [31:0] vel_reg [3];
    logic [31:0] acc_in_reg [3];
    logic [15:0] dt_reg;
    logic [31:0] dt2_reg;
    logic signed [49:0] drift_reg;
    logic signed [49:0] dv_reg;
    logic signed [64:0] acc_reg;
    logic [63:0] sqx_reg, sqy_reg, lim_reg, s_reg;
    logic        clamp_reg, sat_reg;

    // Square root unit.
    logic [63:0] sq_n_reg;
    logic [34:0] sq_rem_reg;
    logic [31:0] root_reg;

    // Divider unit.
    logic [62:0] num_reg;
    logic [31:0] num_lo_reg;
    logic [32:0] div_rem_reg;
    logic [31:0] quot_reg;
    logic        neg_reg;

    // Shared multiplier operands.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;

    logic [31:0] cur_vel, cur_acc;
    logic signed [35:0] pos_sum, vel_sum;
    logic [34:0] sq_trial_sh;
    logic [33:0] sq_trial;
    logic [32:0] div_sh;
    logic [31:0] v_comp;

    assign cur_vel = vel_reg[cmd.axis];
    assign cur_acc = acc_in_reg[cmd.axis];
    assign v_comp  = vel_reg[{1'b0, cmd.comp}];

    // Operand selection for the one multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_DT2:
            begin
                mul_a = {17'd0, dt_reg};
                mul_b = {17'd0, dt_reg};
            end
            OP_DRIFT:
            begin
                mul_a = {cur_vel[31], cur_vel};
                mul_b = {17'd0, dt_reg};
            end
            OP_DV:
            begin
                mul_a = {cur_acc[31], cur_acc};
                mul_b = {17'd0, dt_reg};
            end
            OP_ACC:
            begin
                mul_a = {cur_acc[31], cur_acc};
                mul_b = {1'b0, dt2_reg};
            end
            OP_SQX:
            begin
                mul_a = {vel_reg[0][31], vel_reg[0]};
                mul_b = {vel_reg[0][31], vel_reg[0]};
            end
            OP_SQY:
            begin
                mul_a = {vel_reg[1][31], vel_reg[1]};
                mul_b = {vel_reg[1][31], vel_reg[1]};
            end
            OP_LIM:
            begin
                mul_a = {2'd0, max_speed};
                mul_b = {2'd0, max_speed};
            end
            OP_DIV_MUL:
            begin
                mul_a = v_comp[31] ? -$signed({v_comp[31], v_comp})
                                   : $signed({1'b0, v_comp});
                mul_b = {2'd0, max_speed};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Position and velocity sums of the update step, with floor shifts.
    assign pos_sum = 36'($signed(pos_reg[cmd.axis]))
                   + 36'(drift_reg >>> 16)
                   + 36'(acc_reg >>> 33);
    assign vel_sum = 36'($signed(cur_vel)) + 36'(dv_reg >>> 16);

    // One step of the digit-by-digit square root.
    assign sq_trial_sh = {sq_rem_reg[32:0], sq_n_reg[63:62]};
    assign sq_trial    = {root_reg, 2'b01};

    // One step of the restoring divider.
    assign div_sh = {div_rem_reg[31:0], num_lo_reg[31]};

    assign sts.need_clamp = clamp_reg;

    // Control flags of the item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            clamp_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else if (cmd.op == OP_UPDATE)
        begin
            sat_reg <= sat_reg | ovf32(pos_sum) | ovf32(vel_sum);
        end
        else if (cmd.op == OP_TEST)
        begin
            clamp_reg <= (s_reg > lim_reg);
        end
    end

    // Body state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_LOAD && in_kind == KIND_RESTART)
        begin
            pos_reg[0] <= start_x;
            pos_reg[1] <= start_y;
            pos_reg[2] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_UPDATE)
        begin
            pos_reg[cmd.axis] <= sat32(pos_sum);
            vel_reg[cmd.axis] <= sat32(vel_sum);
        end
        else if (cmd.store)
        begin
            vel_reg[{1'b0, cmd.comp}] <= neg_reg ? (32'd0 - quot_reg) : quot_reg;
        end
    end

    // Working registers of the integrate and clamp steps.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                acc_in_reg[0] <= in_accel_x;
                acc_in_reg[1] <= in_accel_y;
                acc_in_reg[2] <= in_accel_w;
                dt_reg        <= in_dt;
            end
            OP_DT2:   dt2_reg   <= prod[31:0];
            OP_DRIFT: drift_reg <= prod[49:0];
            OP_DV:    dv_reg    <= prod[49:0];
            OP_ACC:   acc_reg   <= prod[64:0];
            OP_SQX:   sqx_reg   <= prod[63:0];
            OP_SQY:   sqy_reg   <= prod[63:0];
            OP_LIM:
            begin
                lim_reg <= prod[63:0];
                s_reg   <= sqx_reg + sqy_reg;
            end
            OP_SQRT_INIT:
            begin
                sq_n_reg   <= s_reg;
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            OP_SQRT_STEP:
            begin
                sq_n_reg <= {sq_n_reg[61:0], 2'b00};
                if (sq_trial_sh >= {1'b0, sq_trial})
                begin
                    sq_rem_reg <= sq_trial_sh - {1'b0, sq_trial};
                    root_reg   <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg <= sq_trial_sh;
                    root_reg   <= {root_reg[30:0], 1'b0};
                end
            end
            OP_DIV_MUL:
            begin
                num_reg <= prod[62:0];
                neg_reg <= v_comp[31];
            end
            OP_DIV_LOAD:
            begin
                div_rem_reg <= {2'd0, num_reg[62:32]};
                num_lo_reg  <= num_reg[31:0];
                quot_reg    <= '0;
            end
            OP_DIV_STEP:
            begin
                num_lo_reg <= {num_lo_reg[30:0], 1'b0};
                if (div_sh >= {1'b0, root_reg})
                begin
                    div_rem_reg <= div_sh - {1'b0, root_reg};
                    quot_reg    <= {quot_reg[30:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= div_sh;
                    quot_reg    <= {quot_reg[30:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register, loaded when the result is published.
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            res_pos_x     <= pos_reg[0];
            res_pos_y     <= pos_reg[1];
            res_heading   <= pos_reg[2];
            res_vel_x     <= vel_reg[0];
            res_vel_y     <= vel_reg[1];
            res_spin      <= vel_reg[2];
            res_clamped   <= clamp_reg;
            res_saturated <= sat_reg;
        end
    end

endmodule
